@@ hw/rtl/grouped_count_aggregator_macros.svh @@
// Assertion macros for the grouped count aggregator.
// Used by the checker file; no other dependencies.
`ifndef GROUPED_COUNT_AGGREGATOR_MACROS_SVH
`define GROUPED_COUNT_AGGREGATOR_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define GCA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grouped_count_aggregator: assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define GCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grouped_count_aggregator: assertion failed");

`endif

@@ hw/rtl/gca_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the grouped count aggregator.
// No dependencies.
package gca_pkg;

	localparam int DEFAULT_MAX_GROUPS = 1024;
	localparam int ACT_W   = 2;
	localparam int GID_W   = 10;
	localparam int CNT_W   = 64;
	localparam int TOTAL_W = 11;
	localparam int ERR_W   = 2;
	localparam int MODE_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ROW    = 2'd0,
		ACT_MERGE  = 2'd1,
		ACT_RESIZE = 2'd2,
		ACT_READ   = 2'd3
	} gca_action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALL   = 2'd0,
		MODE_VALID = 2'd1,
		MODE_NULL  = 2'd2
	} gca_mode_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 2'd0,
		ERR_INACTIVE = 2'd1,
		ERR_CLAMP    = 2'd2
	} gca_err_t;

	// Word index of the count mode register on the configuration port.
	localparam logic REG_COUNT_MODE = 1'b0;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		logic                wr_en;
		logic                zero_cnt;
		logic [GID_W-1:0]    gid;
		logic [CNT_W-1:0]    inc;
		logic [TOTAL_W-1:0]  total;
		gca_err_t            err;
	} gca_cmd_t;

	// Status reported by the back end.
	typedef struct packed {
		logic init_done;
	} gca_status_t;

endpackage

@@ hw/rtl/gca_ifs.sv @@
`timescale 1ns / 1ps
// Stream interfaces for the input items and the result items.
// Depends on gca_pkg.
interface gca_item_if;
	import gca_pkg::*;
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [GID_W-1:0]   group_idx;
	logic               value_valid;
	logic [CNT_W-1:0]   partial_count;
	logic [TOTAL_W-1:0] new_group_count;

	modport source (output valid, action, group_idx, value_valid, partial_count,
		new_group_count, input ready);
	modport sink (input valid, action, group_idx, value_valid, partial_count,
		new_group_count, output ready);
endinterface

interface gca_result_if;
	import gca_pkg::*;
	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   count_value;
	logic [TOTAL_W-1:0] active_groups;
	logic [ERR_W-1:0]   error_code;

	modport source (output valid, count_value, active_groups, error_code, input ready);
	modport sink (input valid, count_value, active_groups, error_code, output ready);
endinterface

@@ hw/rtl/gca_queue.sv @@
`timescale 1ns / 1ps
// Small FIFO of classified commands between the front and back ends.
// Depends on gca_pkg.
module gca_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gca_pkg::gca_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output gca_pkg::gca_cmd_t head
);
	import gca_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	gca_cmd_t           entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  fill_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (fill_q == CNT_QW'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

@@ hw/rtl/gca_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input items, checks group ids, tracks the active group
// count and turns each item into a command. Depends on gca_pkg, gca_ifs.
module gca_front #(
	parameter int MAX_GROUPS = gca_pkg::DEFAULT_MAX_GROUPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	gca_item_if.sink                     item,
	input  logic [gca_pkg::MODE_W-1:0]   count_mode,
	input  gca_pkg::gca_status_t         status,
	input  logic                         q_full,
	output logic                         push,
	output gca_pkg::gca_cmd_t            cmd
);
	import gca_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_next;
	logic [TOTAL_W-1:0] req;
	logic               inactive;
	logic [CNT_W-1:0]   row_inc;

	assign item.ready = !q_full && status.init_done;
	assign push       = item.valid && item.ready;
	assign inactive   = ({1'b0, item.group_idx} >= total_q);

	always_comb begin
		unique case (count_mode)
			MODE_ALL:   row_inc = CNT_W'(1);
			MODE_VALID: row_inc = CNT_W'(item.value_valid);
			MODE_NULL:  row_inc = CNT_W'(!item.value_valid);
			default:    row_inc = '0;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.gid      = item.group_idx;
		cmd.total    = total_q;
		cmd.err      = ERR_OK;
		total_next   = total_q;
		req          = item.new_group_count;
		unique case (item.action)
			ACT_RESIZE: begin
				if (32'(item.new_group_count) > 32'(MAX_GROUPS)) begin
					req     = TOTAL_W'(MAX_GROUPS);
					cmd.err = ERR_CLAMP;
				end
				if (req > total_q) begin
					total_next = req;
				end
				cmd.total    = total_next;
				cmd.zero_cnt = 1'b1;
			end
			ACT_ROW: begin
				cmd.wr_en = !inactive;
				cmd.inc   = row_inc;
			end
			ACT_MERGE: begin
				cmd.wr_en = !inactive;
				cmd.inc   = item.partial_count;
			end
			ACT_READ: begin
				cmd.wr_en = 1'b0;
			end
		endcase
		if (item.action != ACT_RESIZE && inactive) begin
			cmd.err      = ERR_INACTIVE;
			cmd.zero_cnt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (push) begin
			total_q <= total_next;
		end
	end
endmodule

@@ hw/rtl/gca_back.sv @@
`timescale 1ns / 1ps
// Back end: holds the count memory, clears it after reset, reads it for each command
// into a result register and writes back active rows and merges. Depends on gca_pkg, gca_ifs.
module gca_back #(
	parameter int MAX_GROUPS = gca_pkg::DEFAULT_MAX_GROUPS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  gca_pkg::gca_cmd_t     q_head,
	output logic                  pop,
	output gca_pkg::gca_status_t  status,
	gca_result_if.source          result
);
	import gca_pkg::*;

	localparam int GROUP_SPACE = 2 ** GID_W;
	localparam int MEM_DEPTH   = (MAX_GROUPS < GROUP_SPACE) ? MAX_GROUPS : GROUP_SPACE;
	localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_RMW
	} back_state_t;

	back_state_t         state_q;
	logic [AW-1:0]       clr_q;
	logic                clr_last;
	gca_cmd_t            cmd_q;
	logic [CNT_W-1:0]    mem_q [MEM_DEPTH];
	logic [CNT_W-1:0]    rd_data_q;
	logic [CNT_W-1:0]    sum;
	logic                out_free;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [CNT_W-1:0]    mem_wdata;
	logic                res_valid_q;
	logic [CNT_W-1:0]    res_count_q;
	logic [TOTAL_W-1:0]  res_active_q;
	logic [ERR_W-1:0]    res_err_q;

	assign clr_last         = (clr_q == AW'(MEM_DEPTH - 1));
	assign pop              = (state_q == B_IDLE) && q_valid;
	assign out_free         = !res_valid_q || result.ready;
	assign sum              = rd_data_q + cmd_q.inc;
	assign status.init_done = (state_q != B_CLEAR);

	assign mem_we    = (state_q == B_CLEAR) || ((state_q == B_RMW) && out_free && cmd_q.wr_en);
	assign mem_waddr = (state_q == B_CLEAR) ? clr_q : cmd_q.gid[AW-1:0];
	assign mem_wdata = (state_q == B_CLEAR) ? '0 : sum;

	assign result.valid         = res_valid_q;
	assign result.count_value   = res_count_q;
	assign result.active_groups = res_active_q;
	assign result.error_code    = res_err_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q <= mem_q[q_head.gid[AW-1:0]];
			cmd_q     <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			res_valid_q  <= 1'b0;
			res_count_q  <= '0;
			res_active_q <= '0;
			res_err_q    <= '0;
		end else begin
			if (result.ready && !((state_q == B_RMW) && out_free)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					if (clr_last) begin
						state_q <= B_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_RMW;
					end
				end
				B_RMW: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_count_q  <= cmd_q.zero_cnt ? '0 : sum;
						res_active_q <= cmd_q.total;
						res_err_q    <= cmd_q.err;
						state_q      <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hw/rtl/grouped_count_aggregator.sv @@
`timescale 1ns / 1ps
// Grouped count aggregator: each transferred item is classified and queued. The back
// end pops a command and reads its count, then registers the result, writing the sum
// back for active row and merge items; it takes no new command until that is done.
// Reset: count mode 1, no active groups, then a clearing pass zeroes the count memory's
// min(MAX_GROUPS, 1024) entries while item.ready stays low (config writes still work).
// Depends on gca_pkg, gca_ifs, gca_queue, gca_front, gca_back.
module grouped_count_aggregator #(
	parameter int MAX_GROUPS = gca_pkg::DEFAULT_MAX_GROUPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gca_item_if.sink                      item,
	gca_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gca_pkg::PADDR_W-1:0]   paddr,
	input  logic [gca_pkg::PDATA_W-1:0]   pwdata,
	output logic [gca_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import gca_pkg::*;

	// The only configuration register is the count mode. Writes complete in the
	// access phase; the port never inserts wait states. Address bit 2 selects the
	// word, so any address outside word 0 is ignored on write and reads as zero.
	logic [MODE_W-1:0] count_mode_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_mode_q <= MODE_VALID;
		end else if (cfg_wr && paddr[2] == REG_COUNT_MODE) begin
			count_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_COUNT_MODE) ? PDATA_W'(count_mode_q) : '0;

	// The front end owns the active group count, so it can classify every item
	// (range check, resize clamping, row increment) the moment it is transferred.
	// Commands then wait in a short queue; the back end drains it at its own pace
	// and holds each result in an output register until the sink takes it.
	gca_cmd_t    push_cmd;
	gca_cmd_t    q_head;
	gca_status_t status;
	logic        push;
	logic        q_full;
	logic        q_valid;
	logic        pop;

	gca_front #(
		.MAX_GROUPS (MAX_GROUPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.count_mode (count_mode_q),
		.status     (status),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	gca_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// The back end reads a group's count when it pops a command and writes the sum
	// once the result register is free; it takes no new command until the previous
	// write is done, so a repeated group always sees its own updated count.
	gca_back #(
		.MAX_GROUPS (MAX_GROUPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.status  (status),
		.result  (result)
	);
endmodule

@@ hw/rtl/gca_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the grouped count aggregator, bound to the top level.
// Depends on gca_pkg and grouped_count_aggregator_macros.svh.
`include "grouped_count_aggregator_macros.svh"

module gca_checker #(
	parameter int MAX_GROUPS = gca_pkg::DEFAULT_MAX_GROUPS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [gca_pkg::CNT_W-1:0]     res_count,
	input logic [gca_pkg::TOTAL_W-1:0]   res_active,
	input logic [gca_pkg::ERR_W-1:0]     res_err
);
	import gca_pkg::*;

	// A stalled result stays offered and unchanged.
	`GCA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`GCA_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable({res_count, res_active, res_err}))

	// A rejected group id never reports a count.
	`GCA_ASSERT_IMPLIES(a_inactive_zero, clk, arst_n, res_valid && res_err == ERR_INACTIVE, res_count == '0)

	// A clamped resize always leaves the table at full capacity.
	`GCA_ASSERT_IMPLIES(a_clamp_full, clk, arst_n, res_valid && res_err == ERR_CLAMP, 32'(res_active) == 32'(MAX_GROUPS) && res_count == '0)
endmodule

bind grouped_count_aggregator gca_checker #(
	.MAX_GROUPS (MAX_GROUPS)
) u_gca_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_count  (result.count_value),
	.res_active (result.active_groups),
	.res_err    (result.error_code)
);
